// ----- rtl/kqt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqt_pkg
// Shared constants, field widths, command and status codes, and the ASCII
// case-folding helper for the keyed quantity table.
// ----------------------------------------------------------------------------
package kqt_pkg;

    // Defaults for the top-level parameters.
    localparam int CAPACITY_DEF   = 128;
    localparam int KEY_CHARS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed transaction field widths.
    localparam int NAME_KEY_W  = 64;
    localparam int AMOUNT_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 7;
    localparam int COUNT_OUT_W = 16;
    localparam int USED_W      = 8;

    // Commands.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DECREMENT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd5;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;

    // Folds ASCII A-Z to lower case and passes every other byte through.
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CHAR_CASE;
        end
        return r;
    endfunction

endpackage

// ----- rtl/kqt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqt_req_if / kqt_rsp_if
// Valid/ready channels for table commands and for their results.
// ----------------------------------------------------------------------------
interface kqt_req_if import kqt_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [NAME_KEY_W-1:0] name_key;
    logic [AMOUNT_W-1:0]   amount;

    modport source (output valid, output cmd, output name_key, output amount, input ready);
    modport sink   (input valid, input cmd, input name_key, input amount, output ready);
endinterface

interface kqt_rsp_if import kqt_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot;
    logic [COUNT_OUT_W-1:0] count_after;
    logic [USED_W-1:0]      entries_used;

    modport source (output valid, output status, output slot, output count_after,
                    output entries_used, input ready);
    modport sink   (input valid, input status, input slot, input count_after,
                    input entries_used, output ready);
endinterface

// ----- rtl/keyed_quantity_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_quantity_table_unit
// Ordered table of named counts held in one entry RAM. Adds merge or append,
// removes decrement or delete with compaction of the later entries.
//
//   channel  direction  payload
//   req      in         cmd, name_key, amount
//   rsp      out        status, slot, count_after, entries_used
//
// The key search reads one entry per cycle from the entry RAM read port; a
// rejected add on a full table skips the search and goes straight to the
// report. A delete then moves each later entry down one place per cycle.
// Reset clears the fill count and the control state; the RAM needs no clearing pass.
// A stalled result waits in the output register while the next command is
// taken; its own result waits for that register to drain.
// ----------------------------------------------------------------------------
module keyed_quantity_table_unit import kqt_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_CHARS  = KEY_CHARS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    kqt_req_if.sink   req,
    kqt_rsp_if.source rsp
);

    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam int ENTRY_W  = KEY_BITS + COUNT_BITS;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]    want_reg, want_next;
    logic [KEY_BITS-1:0]    kform_reg, kform_next;
    logic [AMOUNT_W-1:0]    amount_reg, amount_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]       sh_src_reg, sh_src_next;
    logic [IDX_W-1:0]       sh_dst_reg, sh_dst_next;
    logic                   sh_pend_reg, sh_pend_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic [COUNT_BITS-1:0]  res_count_reg, res_count_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [USED_W-1:0]      out_used_reg, out_used_next;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]     mem_rdata;

    logic [KEY_CHARS:0]     alive;
    logic [KEY_BITS-1:0]    key_keep;
    logic [KEY_BITS-1:0]    key_fold;
    logic [KEY_BITS-1:0]    rd_key;
    logic [KEY_BITS-1:0]    rd_key_fold;
    logic [COUNT_BITS-1:0]  rd_count;
    logic                   hit;

    logic [SUM_W-1:0]       cnt_ext, amt_ext, cmax_ext, sum_ext;
    logic [COUNT_BITS-1:0]  merged_cnt, append_cnt, dec_cnt;
    logic                   del_entry;

    // Key form: bytes up to the first zero byte are kept, the rest are zero.
    assign alive[0] = 1'b1;
    for (genvar i = 0; i < KEY_CHARS; i++)
    begin : g_key
        assign alive[i+1] = alive[i] && (req.name_key[8*i +: 8] != 8'h00);
        assign key_keep[8*i +: 8]    = alive[i+1] ? req.name_key[8*i +: 8] : 8'h00;
        assign key_fold[8*i +: 8]    = alive[i+1] ? fold_char(req.name_key[8*i +: 8]) : 8'h00;
        assign rd_key_fold[8*i +: 8] = fold_char(rd_key[8*i +: 8]);
    end

    assign rd_key   = mem_rdata[KEY_BITS-1:0];
    assign rd_count = mem_rdata[ENTRY_W-1:KEY_BITS];
    assign hit      = pend_reg && (rd_key_fold == want_reg);

    assign cnt_ext    = SUM_W'(rd_count);
    assign amt_ext    = SUM_W'(amount_reg);
    assign cmax_ext   = SUM_W'({COUNT_BITS{1'b1}});
    assign sum_ext    = cnt_ext + amt_ext;
    assign merged_cnt = (sum_ext > cmax_ext) ? COUNT_BITS'(cmax_ext) : COUNT_BITS'(sum_ext);
    assign append_cnt = (amt_ext > cmax_ext) ? COUNT_BITS'(cmax_ext) : COUNT_BITS'(amt_ext);
    assign del_entry  = (amt_ext >= cnt_ext);
    assign dec_cnt    = rd_count - COUNT_BITS'(amount_reg);

    kqt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        want_next       = want_reg;
        kform_next      = kform_reg;
        amount_next     = amount_reg;
        used_next       = used_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        sh_src_next     = sh_src_reg;
        sh_dst_next     = sh_dst_reg;
        sh_pend_next    = sh_pend_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        rsp_valid_next  = rsp_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        out_used_next   = out_used_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = scan_reg[IDX_W-1:0];

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    want_next   = key_fold;
                    kform_next  = key_keep;
                    amount_next = req.amount;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    if (req.cmd == CMD_ADD && used_reg == CNT_W'(CAPACITY))
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        res_count_next  = '0;
                        state_next      = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                mem_raddr = scan_reg[IDX_W-1:0];
                if (hit)
                begin
                    res_slot_next = pend_idx_reg;
                    if (cmd_reg == CMD_ADD)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = pend_idx_reg;
                        mem_wdata       = {merged_cnt, rd_key};
                        res_status_next = ST_MERGED;
                        res_count_next  = merged_cnt;
                        state_next      = S_REPORT;
                    end
                    else if (del_entry)
                    begin
                        res_status_next = ST_DELETED;
                        res_count_next  = '0;
                        sh_src_next     = CNT_W'(pend_idx_reg) + CNT_W'(1);
                        sh_dst_next     = pend_idx_reg;
                        sh_pend_next    = 1'b0;
                        state_next      = S_SHIFT;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = pend_idx_reg;
                        mem_wdata       = {dec_cnt, rd_key};
                        res_status_next = ST_DECREMENT;
                        res_count_next  = dec_cnt;
                        state_next      = S_REPORT;
                    end
                end
                else if (scan_reg >= used_reg)
                begin
                    // Every valid entry has been compared without a match.
                    if (cmd_reg == CMD_ADD)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = used_reg[IDX_W-1:0];
                        mem_wdata       = {append_cnt, kform_reg};
                        used_next       = used_reg + CNT_W'(1);
                        res_status_next = ST_APPENDED;
                        res_slot_next   = used_reg[IDX_W-1:0];
                        res_count_next  = append_cnt;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_count_next  = '0;
                    end
                    state_next = S_REPORT;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                // Read entry src while the entry read last cycle lands one place lower.
                mem_raddr = sh_src_reg[IDX_W-1:0];
                if (sh_pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = sh_dst_reg;
                    mem_wdata   = mem_rdata;
                    sh_dst_next = sh_dst_reg + IDX_W'(1);
                end
                if (sh_src_reg >= used_reg)
                begin
                    used_next  = used_reg - CNT_W'(1);
                    state_next = S_REPORT;
                end
                else
                begin
                    sh_pend_next = 1'b1;
                    sh_src_next  = sh_src_reg + CNT_W'(1);
                end
            end

            S_REPORT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = SLOT_W'(res_slot_reg);
                    out_count_next  = COUNT_OUT_W'(res_count_reg);
                    out_used_next   = USED_W'(used_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            sh_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            sh_pend_reg   <= sh_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        want_reg       <= want_next;
        kform_reg      <= kform_next;
        amount_reg     <= amount_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        sh_src_reg     <= sh_src_next;
        sh_dst_reg     <= sh_dst_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        out_used_reg   <= out_used_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.count_after  = out_count_reg;
    assign rsp.entries_used = out_used_reg;

endmodule

// ----- rtl/kqt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/kqt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqt_checker
// Port-level checks on the keyed quantity table, bound to the top level.
// ----------------------------------------------------------------------------
module kqt_checker import kqt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [STATUS_W-1:0]    rsp_status,
    input logic [SLOT_W-1:0]      rsp_slot,
    input logic [COUNT_OUT_W-1:0] rsp_count_after,
    input logic [USED_W-1:0]      rsp_entries_used
);

    // A stalled result holds still.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
            && $stable(rsp_count_after) && $stable(rsp_entries_used))
        else $error("result changed while stalled");

    // The unit works on one command at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while another is in progress");

    // A rejected add is only reported against a full table.
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_entries_used == USED_W'(CAPACITY))
        else $error("full rejection with free entries");

    // Results that touch no surviving entry report a zero count.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND
            || rsp_status == ST_DELETED)
        |-> rsp_count_after == '0 && (rsp_status == ST_DELETED || rsp_slot == '0))
        else $error("nonzero count or slot for an untouched entry");

endmodule

bind keyed_quantity_table_unit kqt_checker #(
    .CAPACITY (CAPACITY)
) u_kqt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_slot         (rsp.slot),
    .rsp_count_after  (rsp.count_after),
    .rsp_entries_used (rsp.entries_used)
);

// ----- tb/keyed_quantity_table_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_quantity_table_unit_test
// Drives add and remove commands into the keyed quantity table and checks
// every result against a shadow copy of the table kept in the testbench.
// It starts with a directed pass over case folding, saturation, zero amounts,
// missing keys and deletes with compaction. Four phases follow, each with
// different sender and receiver idling. Each phase fills the table to
// capacity, probes the full-table rules, runs mixed traffic with noise keys,
// and then drains most entries again.
// ----------------------------------------------------------------------------
module keyed_quantity_table_unit_test;
    import kqt_pkg::*;

    localparam int TABLE_DEPTH    = CAPACITY_DEF;
    localparam int POOL_SIZE      = 192;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MIXED_ITEMS    = 90;
    localparam int DRAIN_FLOOR    = 16;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_OUT_W-1:0] count_after;
        logic [USED_W-1:0]      entries_used;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    kqt_req_if req_ch ();
    kqt_rsp_if rsp_ch ();

    keyed_quantity_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table.
    logic [NAME_KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
    logic [COUNT_OUT_W-1:0] shadow_counts [TABLE_DEPTH];
    int                     shadow_used = 0;

    table_result_t          pending_results [$];
    logic [NAME_KEY_W-1:0]  name_pool [POOL_SIZE];
    int                     next_pool_id = 0;
    int                     mismatches = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     quiet_cycles = 0;
    bit                     req_up = 1'b0;

    always #2 clk = ~clk;

    // Cuts a raw key at its first zero byte and optionally folds A-Z.
    function automatic logic [NAME_KEY_W-1:0] canon_key(input logic [NAME_KEY_W-1:0] raw,
                                                       input bit fold);
        logic [NAME_KEY_W-1:0] k;
        logic [7:0]            b;
        bit                    ended;
        k = '0;
        ended = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            b = raw[8*i +: 8];
            if (b == 8'h00)
                ended = 1'b1;
            if (!ended)
            begin
                if (fold && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
                    b = b + CHAR_CASE;
                k[8*i +: 8] = b;
            end
        end
        return k;
    endfunction

    function automatic int find_entry(input logic [NAME_KEY_W-1:0] raw);
        logic [NAME_KEY_W-1:0] want;
        want = canon_key(raw, 1'b1);
        for (int i = 0; i < shadow_used; i++)
        begin
            if (canon_key(shadow_keys[i], 1'b1) == want)
                return i;
        end
        return shadow_used;
    endfunction

    // Applies one command to the shadow table and returns the result it produces.
    function automatic table_result_t apply_table_op(input logic op,
                                                     input logic [NAME_KEY_W-1:0] key,
                                                     input logic [AMOUNT_W-1:0] amount);
        table_result_t r;
        int            idx;
        logic [16:0]   sum;
        r = '0;
        if (op == CMD_ADD)
        begin
            // A full table rejects every add, even for a key already present.
            if (shadow_used >= TABLE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                idx = find_entry(key);
                if (idx < shadow_used)
                begin
                    sum = {1'b0, shadow_counts[idx]} + {1'b0, amount};
                    shadow_counts[idx] = sum[16] ? 16'hFFFF : sum[15:0];
                    r.status = ST_MERGED;
                end
                else
                begin
                    idx = shadow_used;
                    shadow_keys[idx] = canon_key(key, 1'b0);
                    shadow_counts[idx] = amount;
                    shadow_used++;
                    r.status = ST_APPENDED;
                end
                r.slot = SLOT_W'(idx);
                r.count_after = shadow_counts[idx];
            end
        end
        else
        begin
            idx = find_entry(key);
            if (idx >= shadow_used)
            begin
                r.status = ST_NOT_FOUND;
            end
            else if (amount >= shadow_counts[idx])
            begin
                for (int i = idx; i + 1 < shadow_used; i++)
                begin
                    shadow_keys[i] = shadow_keys[i + 1];
                    shadow_counts[i] = shadow_counts[i + 1];
                end
                shadow_used--;
                r.status = ST_DELETED;
                r.slot = SLOT_W'(idx);
            end
            else
            begin
                shadow_counts[idx] = shadow_counts[idx] - amount;
                r.status = ST_DECREMENT;
                r.slot = SLOT_W'(idx);
                r.count_after = shadow_counts[idx];
            end
        end
        r.entries_used = USED_W'(shadow_used);
        return r;
    endfunction

    function automatic logic [NAME_KEY_W-1:0] ascii_key(input string s);
        logic [NAME_KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            k[8*i +: 8] = s[i];
        return k;
    endfunction

    function automatic logic [NAME_KEY_W-1:0] random_name();
        logic [NAME_KEY_W-1:0] k;
        int                    len;
        int                    pick;
        k = '0;
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                k[8*i +: 8] = 8'h61 + 8'($urandom_range(25));
            else if (pick < 92)
                k[8*i +: 8] = 8'h30 + 8'($urandom_range(9));
            else
                k[8*i +: 8] = 8'($urandom_range(255, 128));
        end
        return k;
    endfunction

    function automatic void build_name_pool();
        logic [NAME_KEY_W-1:0] k;
        bit                    taken;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            do
            begin
                k = random_name();
                taken = 1'b0;
                for (int j = 0; j < i; j++)
                begin
                    if (name_pool[j] == k)
                        taken = 1'b1;
                end
            end
            while (taken);
            name_pool[i] = k;
        end
    endfunction

    // Same key under a random mix of cases, sometimes with junk after the terminator.
    function automatic logic [NAME_KEY_W-1:0] spell_variant(input logic [NAME_KEY_W-1:0] base);
        logic [NAME_KEY_W-1:0] k;
        logic [7:0]            b;
        int                    term;
        k = base;
        term = 8;
        for (int i = 0; i < 8; i++)
        begin
            b = base[8*i +: 8];
            if (term == 8)
            begin
                if (b == 8'h00)
                    term = i;
                else if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
                         && $urandom_range(1) == 1)
                    k[8*i +: 8] = b ^ CHAR_CASE;
            end
        end
        if (term < 7 && $urandom_range(3) == 0)
        begin
            for (int i = term + 1; i < 8; i++)
                k[8*i +: 8] = 8'($urandom_range(255));
        end
        return k;
    endfunction

    function automatic logic [AMOUNT_W-1:0] rand_amount();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return '1;
        else if (pick < 60)
            return AMOUNT_W'($urandom_range(16, 1));
        return AMOUNT_W'($urandom_range(65535));
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expected,
                     actual);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        table_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result: status %0d slot %0d count %0d used %0d", $time,
                     rsp_ch.status, rsp_ch.slot, rsp_ch.count_after, rsp_ch.entries_used);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_ch.status));
            compare_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
            compare_field("count_after", 32'(want.count_after), 32'(rsp_ch.count_after));
            compare_field("entries_used", 32'(want.entries_used), 32'(rsp_ch.entries_used));
        end
    endfunction

    // Result side: random backpressure and checking of each accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one command. Valid stays high afterwards so that back-to-back
    // commands need no second assignment in the same time step.
    task automatic issue_command(input logic op, input logic [NAME_KEY_W-1:0] key,
                                 input logic [AMOUNT_W-1:0] amount);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            if (req_up)
            begin
                req_ch.valid <= 1'b0;
                req_up = 1'b0;
            end
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_up = 1'b1;
        req_ch.cmd <= op;
        req_ch.name_key <= key;
        req_ch.amount <= amount;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(apply_table_op(op, key, amount));
    endtask

    task automatic hold_until_drained();
        if (req_up)
        begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic test_directed_cases();
        issue_command(CMD_REMOVE, ascii_key("ghost"), 16'd1);
        issue_command(CMD_ADD, ascii_key("apple"), 16'd5);
        issue_command(CMD_ADD, ascii_key("APPLE"), 16'd7);
        // Bytes above the terminating zero must not take part in the match.
        issue_command(CMD_ADD, ascii_key("ApPlE") | 64'hA5C3_0000_0000_0000, 16'hFFF0);
        issue_command(CMD_ADD, ascii_key("apple"), 16'hFFFF);
        issue_command(CMD_ADD, 64'h0, 16'd0);
        issue_command(CMD_REMOVE, 64'hFF00, 16'd0);
        issue_command(CMD_REMOVE, ascii_key("pear"), 16'd3);
        issue_command(CMD_ADD, ascii_key("pear"), 16'd0);
        issue_command(CMD_ADD, ascii_key("Plum"), 16'hFFFF);
        issue_command(CMD_REMOVE, ascii_key("apple"), 16'd1);
        issue_command(CMD_REMOVE, ascii_key("pLUM"), 16'd0);
        issue_command(CMD_REMOVE, ascii_key("PEAR"), 16'd0);
        // Characters next to the letter ranges are not folded.
        issue_command(CMD_ADD, 64'h40, 16'd1);
        issue_command(CMD_ADD, 64'h60, 16'd2);
        issue_command(CMD_ADD, 64'h5B, 16'd3);
        issue_command(CMD_ADD, 64'h7B, 16'd4);
        issue_command(CMD_ADD, ascii_key("Z"), 16'd5);
        issue_command(CMD_ADD, ascii_key("z"), 16'd6);
        issue_command(CMD_ADD, '1, 16'h8000);
        issue_command(CMD_ADD, '1, 16'h7FFF);
        issue_command(CMD_ADD, ascii_key("ABCDEFGH"), 16'd1);
        issue_command(CMD_ADD, ascii_key("abcdefgh"), 16'd2);
        issue_command(CMD_REMOVE, ascii_key("Apple"), 16'hFFFF);
        issue_command(CMD_REMOVE, ascii_key("abcdEFGH"), 16'd3);
        hold_until_drained();
    endtask

    task automatic test_fill_to_capacity();
        int pick;
        int idx;
        while (shadow_used < TABLE_DEPTH)
        begin
            pick = $urandom_range(99);
            if (pick < 75 || shadow_used == 0)
            begin
                issue_command(CMD_ADD, spell_variant(name_pool[next_pool_id]), rand_amount());
                next_pool_id = (next_pool_id + 1) % POOL_SIZE;
            end
            else if (pick < 90)
            begin
                idx = $urandom_range(shadow_used - 1);
                issue_command(CMD_ADD, spell_variant(shadow_keys[idx]), rand_amount());
            end
            else
            begin
                idx = $urandom_range(shadow_used - 1);
                issue_command(CMD_REMOVE, spell_variant(shadow_keys[idx]), rand_amount());
            end
        end
    endtask

    task automatic test_full_table();
        int idx;
        idx = $urandom_range(TABLE_DEPTH - 1);
        issue_command(CMD_ADD, spell_variant(shadow_keys[idx]), rand_amount());
        issue_command(CMD_ADD, {$urandom, $urandom}, rand_amount());
        // Deleting the first entry shifts every other entry down.
        issue_command(CMD_REMOVE, spell_variant(shadow_keys[0]), 16'hFFFF);
        issue_command(CMD_ADD, {$urandom, $urandom}, rand_amount());
        issue_command(CMD_ADD, spell_variant(shadow_keys[TABLE_DEPTH - 1]), 16'd1);
        issue_command(CMD_REMOVE, spell_variant(shadow_keys[TABLE_DEPTH - 1]), 16'hFFFF);
        idx = $urandom_range(shadow_used - 1);
        issue_command(CMD_REMOVE, spell_variant(shadow_keys[idx]), shadow_counts[idx]);
        idx = $urandom_range(shadow_used - 1);
        issue_command(CMD_REMOVE, spell_variant(shadow_keys[idx]), 16'd0);
        hold_until_drained();
    endtask

    task automatic test_mixed_traffic(input int items);
        int pick;
        int idx;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                issue_command(1'($urandom_range(1)), {$urandom, $urandom},
                              AMOUNT_W'($urandom_range(65535)));
            end
            else if (pick < 50)
            begin
                idx = $urandom_range(POOL_SIZE - 1);
                issue_command(CMD_ADD, spell_variant(name_pool[idx]), rand_amount());
            end
            else if (pick < 80 && shadow_used > 0)
            begin
                idx = $urandom_range(shadow_used - 1);
                issue_command(CMD_REMOVE, spell_variant(shadow_keys[idx]), rand_amount());
            end
            else
            begin
                idx = $urandom_range(POOL_SIZE - 1);
                issue_command(CMD_REMOVE, spell_variant(name_pool[idx]), rand_amount());
            end
        end
    endtask

    task automatic test_drain_entries();
        int               pick;
        int               idx;
        logic [AMOUNT_W-1:0] amt;
        while (shadow_used > DRAIN_FLOOR)
        begin
            idx = $urandom_range(shadow_used - 1);
            pick = $urandom_range(99);
            if (pick < 50)
                amt = '1;
            else if (pick < 75)
                amt = shadow_counts[idx];
            else
                amt = AMOUNT_W'($urandom_range(15));
            issue_command(CMD_REMOVE, spell_variant(shadow_keys[idx]), amt);
        end
    endtask

    task automatic run_table_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        test_fill_to_capacity();
        test_full_table();
        test_mixed_traffic(MIXED_ITEMS);
        test_drain_entries();
        hold_until_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ADD;
        req_ch.name_key = '0;
        req_ch.amount = '0;
        rsp_ch.ready = 1'b0;
        build_name_pool();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        run_table_phase(0, 0);
        run_table_phase(83, 0);
        run_table_phase(0, 83);
        run_table_phase(7, 7);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
